@@ hw/rtl/vmx_pkg.sv @@
// Shared types, field widths and codes of the voice mixer.
package vmx_pkg;

	localparam int VOICES_DEF       = 8;
	localparam int SAMPLE_WORDS_DEF = 65536;
	localparam int FADE_FRAMES      = 4096;
	localparam int FADE_SH          = $clog2(FADE_FRAMES);
	localparam int FADE_W           = $clog2(FADE_FRAMES + 1);
	localparam int ACC_W            = 28;
	localparam int CFG_IDX_W        = 2;
	localparam int CFG_DATA_W       = 21;
	localparam int IN_DATA_W        = 96;
	localparam int OUT_DATA_W       = 24;

	localparam logic [2:0] CMD_MIX    = 3'd0;
	localparam logic [2:0] CMD_PLAY   = 3'd1;
	localparam logic [2:0] CMD_STOP   = 3'd2;
	localparam logic [2:0] CMD_WRITE  = 3'd3;
	localparam logic [2:0] CMD_SWITCH = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_MASTER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MUSIC  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP   = 2'd2;

	localparam logic signed [ACC_W-1:0] SAT_MAX = 28'sd32767;
	localparam logic signed [ACC_W-1:0] SAT_MIN = -28'sd32768;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_GAIN,
		MUL_INT,
		MUL_SMP,
		MUL_MVOL,
		MUL_MUS
	} mul_op_t;

	typedef struct packed {
		logic    load;
		logic    do_write;
		logic    do_stop;
		logic    do_switch;
		logic    scan_step;
		logic    play_commit;
		logic    frame_init;
		logic    rd_next;
		logic    v_acc;
		logic    mus_update;
		logic    out_load;
		mul_op_t mul_op;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] item_cmd;
		logic       cur_active;
		logic       in_range;
		logic       out_free;
	} dp_stat_t;

endpackage

@@ hw/rtl/voice_mixer_with_music_crossfade.sv @@
// Voice mixer top level: takes one item at a time and walks the voices with one multiplier.
// Mix frame: voices are visited in turn (idle ones skipped, ended ones retired, playing ones
// through gain, interpolation and scaling on the shared multiplier), then the music step; the
// result is valid as s_tready returns when the result register is free. Play: a scan picks a
// free slot, else the oldest voice. Write, stop, switch, other items: handled at dispatch.
// The result register lets the next item start while a result waits for m_tready.
// Reset clears voices, music state, configuration and handshake; the sample store is not cleared.
module voice_mixer_with_music_crossfade #(
	parameter int VOICES = vmx_pkg::VOICES_DEF,
	parameter int SAMPLE_WORDS = vmx_pkg::SAMPLE_WORDS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [0] buffer_start, [16:1] music_sample, [32:17] sound_start, [49:33] sound_length,
	// [58:50] voice_gain, [74:59] sample_address, [90:75] sample_value,
	// [91] next_track_present, [95:92] zero
	input  logic [vmx_pkg::IN_DATA_W-1:0]     s_tdata,
	// [2:0] cmd
	input  logic [2:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [15:0] mixed_sample, [16] clipped, [20:17] voices_playing, [21] music_swapped,
	// [23:22] zero
	output logic [vmx_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [vmx_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [vmx_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import vmx_pkg::*;

	localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

	dp_cmd_t cmd;
	dp_stat_t stat;
	logic [VW-1:0] vidx;
	logic signed [15:0] mixed;
	logic clipped, swapped;
	logic [3:0] playing;

	assign cfg_ready = 1'b1;
	assign m_tdata = {2'b00, swapped, playing, clipped, mixed};

	vmx_ctrl #(.VOICES(VOICES)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd),
		.vidx     (vidx)
	);

	vmx_dp #(.VOICES(VOICES), .SAMPLE_WORDS(SAMPLE_WORDS)) u_dp (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cmd                   (cmd),
		.vidx                  (vidx),
		.stat                  (stat),
		.in_cmd                (s_tuser),
		.in_buffer_start       (s_tdata[0]),
		.in_music_sample       (s_tdata[16:1]),
		.in_sound_start        (s_tdata[32:17]),
		.in_sound_length       (s_tdata[49:33]),
		.in_voice_gain         (s_tdata[58:50]),
		.in_sample_address     (s_tdata[74:59]),
		.in_sample_value       (s_tdata[90:75]),
		.in_next_track_present (s_tdata[91]),
		.cfg_valid             (cfg_valid),
		.cfg_index             (cfg_index),
		.cfg_data              (cfg_data),
		.out_ready             (m_tready),
		.out_valid             (m_tvalid),
		.out_mixed_sample      (mixed),
		.out_clipped           (clipped),
		.out_voices_playing    (playing),
		.out_music_swapped     (swapped)
	);

endmodule

@@ hw/rtl/vmx_ctrl.sv @@
// Sequencer of the voice mixer: dispatches items and walks the voices.
module vmx_ctrl #(
	parameter int VOICES = vmx_pkg::VOICES_DEF,
	localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  vmx_pkg::dp_stat_t  stat,
	output vmx_pkg::dp_cmd_t   cmd,
	output logic [VW-1:0]      vidx
);
	import vmx_pkg::*;

	typedef enum logic [13:0] {
		ST_IDLE = 14'b00000000000001,
		ST_DISP = 14'b00000000000010,
		ST_SCAN = 14'b00000000000100,
		ST_PLAY = 14'b00000000001000,
		ST_VCHK = 14'b00000000010000,
		ST_VRDA = 14'b00000000100000,
		ST_VRDB = 14'b00000001000000,
		ST_VINT = 14'b00000010000000,
		ST_VSMP = 14'b00000100000000,
		ST_VACC = 14'b00001000000000,
		ST_MUS1 = 14'b00010000000000,
		ST_MUS2 = 14'b00100000000000,
		ST_MUS3 = 14'b01000000000000,
		ST_OUT  = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;
	logic [VW-1:0] vidx_q, vidx_d;
	logic last;

	assign last = (vidx_q == VW'(VOICES - 1));
	assign vidx = vidx_q;
	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		vidx_d = vidx_q;
		cmd = '0;
		cmd.mul_op = MUL_NONE;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				vidx_d = '0;
				state_d = ST_IDLE;
				case (stat.item_cmd)
					CMD_MIX: begin
						cmd.frame_init = 1'b1;
						state_d = ST_VCHK;
					end
					CMD_PLAY:   state_d = ST_SCAN;
					CMD_STOP:   cmd.do_stop = 1'b1;
					CMD_WRITE:  cmd.do_write = 1'b1;
					CMD_SWITCH: cmd.do_switch = 1'b1;
					default:    state_d = ST_IDLE;
				endcase
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (!stat.cur_active || last) begin
					state_d = ST_PLAY;
				end else begin
					vidx_d = vidx_q + 1'b1;
				end
			end
			ST_PLAY: begin
				cmd.play_commit = 1'b1;
				state_d = ST_IDLE;
			end
			ST_VCHK: begin
				if (!stat.cur_active) begin
					if (last) begin
						state_d = ST_MUS1;
					end else begin
						vidx_d = vidx_q + 1'b1;
					end
				end else if (stat.in_range) begin
					state_d = ST_VRDA;
				end else begin
					state_d = ST_VACC;
				end
			end
			ST_VRDA: begin
				cmd.mul_op = MUL_GAIN;
				state_d = ST_VRDB;
			end
			ST_VRDB: begin
				cmd.rd_next = 1'b1;
				state_d = ST_VINT;
			end
			ST_VINT: begin
				cmd.mul_op = MUL_INT;
				state_d = ST_VSMP;
			end
			ST_VSMP: begin
				cmd.mul_op = MUL_SMP;
				state_d = ST_VACC;
			end
			ST_VACC: begin
				cmd.v_acc = 1'b1;
				if (last) begin
					state_d = ST_MUS1;
				end else begin
					vidx_d = vidx_q + 1'b1;
					state_d = ST_VCHK;
				end
			end
			ST_MUS1: begin
				cmd.mus_update = 1'b1;
				state_d = ST_MUS2;
			end
			ST_MUS2: begin
				cmd.mul_op = MUL_MVOL;
				state_d = ST_MUS3;
			end
			ST_MUS3: begin
				cmd.mul_op = MUL_MUS;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vidx_q <= '0;
		end else begin
			state_q <= state_d;
			vidx_q <= vidx_d;
		end
	end

endmodule

@@ hw/rtl/vmx_dp.sv @@
// Datapath of the voice mixer: sample store, voice state, shared multiplier, music fade.
module vmx_dp #(
	parameter int VOICES = vmx_pkg::VOICES_DEF,
	parameter int SAMPLE_WORDS = vmx_pkg::SAMPLE_WORDS_DEF,
	localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1,
	localparam int AW = $clog2(SAMPLE_WORDS),
	localparam int CW = $clog2(VOICES + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  vmx_pkg::dp_cmd_t                  cmd,
	input  logic [VW-1:0]                     vidx,
	output vmx_pkg::dp_stat_t                 stat,
	input  logic [2:0]                        in_cmd,
	input  logic                              in_buffer_start,
	input  logic signed [15:0]                in_music_sample,
	input  logic [15:0]                       in_sound_start,
	input  logic [16:0]                       in_sound_length,
	input  logic [8:0]                        in_voice_gain,
	input  logic [15:0]                       in_sample_address,
	input  logic signed [15:0]                in_sample_value,
	input  logic                              in_next_track_present,
	input  logic                              cfg_valid,
	input  logic [vmx_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [vmx_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic signed [15:0]                out_mixed_sample,
	output logic                              out_clipped,
	output logic [3:0]                        out_voices_playing,
	output logic                              out_music_swapped
);
	import vmx_pkg::*;

	logic [2:0]         cmd_q;
	logic               bstart_q;
	logic signed [15:0] msamp_q;
	logic [15:0]        sstart_q;
	logic [16:0]        slen_q;
	logic [8:0]         sgain_q;
	logic [15:0]        saddr_q;
	logic signed [15:0] sval_q;
	logic               next_q;

	logic [8:0]  master_q, musvol_q;
	logic [20:0] step_q;

	logic signed [15:0] mem [SAMPLE_WORDS];
	logic signed [15:0] rdata_q;

	logic [VOICES-1:0] active_q;
	logic [15:0] base_q [VOICES];
	logic [16:0] len_q [VOICES];
	logic [33:0] pos_q [VOICES];
	logic [8:0]  level_q [VOICES];
	logic [31:0] age_q [VOICES];
	logic [31:0] age_ctr_q;
	logic [VW-1:0] slot_q;

	logic signed [15:0] a_q;
	logic [17:0] gain_q;
	logic signed [39:0] prod_q;
	logic signed [ACC_W-1:0] acc_q;

	logic music_open_q, pending_q, switching_q, hold_q, swapped_q, add_q;
	logic [FADE_W-1:0] fade_q;

	logic [17:0] idx;
	logic [16:0] len;
	logic [33:0] pos, pos_new;
	logic in_range, has_next;
	logic [AW+18:0] raddr_w;
	logic [AW+15:0] waddr_w;
	logic signed [15:0] bsel;
	logic signed [16:0] diff, smp;
	logic signed [19:0] ma, mb;
	logic signed [ACC_W-1:0] vc, mus, total;
	logic [CW-1:0] count;

	logic mo_n, po_n, sw_n, hold_n, swp_n, add_n;
	logic [FADE_W-1:0] fade_n;

	assign len = len_q[vidx];
	assign pos = pos_q[vidx];
	assign idx = pos[33:16];
	assign in_range = (idx < 18'(len));
	assign has_next = ((19'(idx) + 19'd1) < 19'(len));
	assign pos_new = in_range ? (pos + 34'(step_q)) : pos;
	assign raddr_w = (AW+19)'(base_q[vidx]) + (AW+19)'(idx) + (AW+19)'(cmd.rd_next);
	assign waddr_w = (AW+16)'(saddr_q);

	assign bsel = has_next ? rdata_q : a_q;
	assign diff = 17'(bsel) - 17'(a_q);
	assign smp = 17'(a_q) + prod_q[32:16];
	assign vc = ACC_W'(prod_q >>> 16);
	assign mus = ACC_W'(prod_q >>> 8);

	assign stat.item_cmd = cmd_q;
	assign stat.cur_active = active_q[vidx];
	assign stat.in_range = in_range;
	assign stat.out_free = !out_valid || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.do_write) begin
			mem[waddr_w[AW-1:0]] <= sval_q;
		end
		rdata_q <= mem[raddr_w[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= in_cmd;
			bstart_q <= in_buffer_start;
			msamp_q <= in_music_sample;
			sstart_q <= in_sound_start;
			slen_q <= in_sound_length;
			sgain_q <= in_voice_gain;
			saddr_q <= in_sample_address;
			sval_q <= in_sample_value;
			next_q <= in_next_track_present;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_q <= 9'd256;
			musvol_q <= 9'd256;
			step_q <= 21'd32768;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MASTER: master_q <= cfg_data[8:0];
				REG_MUSIC:  musvol_q <= cfg_data[8:0];
				REG_STEP:   step_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.mul_op)
			MUL_GAIN: begin
				ma = {11'b0, level_q[vidx]};
				mb = {11'b0, master_q};
			end
			MUL_INT: begin
				ma = 20'(diff);
				mb = {4'b0, pos[15:0]};
			end
			MUL_SMP: begin
				ma = 20'(smp);
				mb = {2'b0, gain_q};
			end
			MUL_MVOL: begin
				ma = {11'b0, musvol_q};
				mb = 20'({1'b0, fade_q});
			end
			MUL_MUS: begin
				ma = 20'(msamp_q);
				mb = {11'b0, prod_q[FADE_SH+8:FADE_SH]};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_op != MUL_NONE) begin
			prod_q <= ma * mb;
		end
		if (cmd.rd_next) begin
			a_q <= rdata_q;
			gain_q <= prod_q[17:0];
		end
		if (cmd.load) begin
			slot_q <= '0;
		end else if (cmd.scan_step) begin
			if (!active_q[vidx]) begin
				slot_q <= vidx;
			end else if (age_q[vidx] < age_q[slot_q]) begin
				slot_q <= vidx;
			end
		end
		if (cmd.play_commit) begin
			base_q[slot_q] <= sstart_q;
			len_q[slot_q] <= slen_q;
			pos_q[slot_q] <= '0;
			level_q[slot_q] <= sgain_q;
			age_q[slot_q] <= age_ctr_q + 32'd1;
		end
		if (cmd.v_acc) begin
			pos_q[vidx] <= pos_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			age_ctr_q <= '0;
			acc_q <= '0;
		end else begin
			if (cmd.do_stop) begin
				active_q <= '0;
			end
			if (cmd.play_commit) begin
				active_q[slot_q] <= 1'b1;
				age_ctr_q <= age_ctr_q + 32'd1;
			end
			if (cmd.frame_init) begin
				acc_q <= '0;
			end
			if (cmd.v_acc) begin
				if (in_range) begin
					acc_q <= acc_q + vc;
				end
				if (pos_new[33:16] >= 18'(len)) begin
					active_q[vidx] <= 1'b0;
				end
			end
		end
	end

	always_comb begin
		mo_n = music_open_q;
		po_n = pending_q;
		sw_n = switching_q;
		hold_n = hold_q;
		fade_n = fade_q;
		swp_n = 1'b0;
		add_n = 1'b0;
		if (musvol_q == 9'd0) begin
			if (switching_q) begin
				mo_n = pending_q;
				po_n = music_open_q;
				sw_n = 1'b0;
				swp_n = 1'b1;
			end
			fade_n = '0;
		end else if (music_open_q || switching_q) begin
			if (switching_q) begin
				if (fade_q != '0) begin
					fade_n = fade_q - 1'b1;
				end else begin
					mo_n = pending_q;
					po_n = music_open_q;
					sw_n = 1'b0;
					swp_n = 1'b1;
					hold_n = 1'b1;
				end
			end else if (fade_q < FADE_W'(FADE_FRAMES)) begin
				fade_n = fade_q + 1'b1;
			end
			add_n = !hold_n && mo_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			music_open_q <= 1'b0;
			pending_q <= 1'b0;
			switching_q <= 1'b0;
			hold_q <= 1'b0;
			fade_q <= '0;
			swapped_q <= 1'b0;
			add_q <= 1'b0;
		end else begin
			if (cmd.do_switch) begin
				pending_q <= next_q;
				switching_q <= 1'b1;
			end
			if (cmd.frame_init && bstart_q) begin
				hold_q <= 1'b0;
			end
			if (cmd.mus_update) begin
				music_open_q <= mo_n;
				pending_q <= po_n;
				switching_q <= sw_n;
				hold_q <= hold_n;
				fade_q <= fade_n;
				swapped_q <= swp_n;
				add_q <= add_n;
			end
		end
	end

	always_comb begin
		count = '0;
		for (int v = 0; v < VOICES; v++) begin
			count = count + CW'(active_q[v]);
		end
	end

	assign total = acc_q + (add_q ? mus : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (total > SAT_MAX) begin
				out_mixed_sample <= 16'sh7fff;
				out_clipped <= 1'b1;
			end else if (total < SAT_MIN) begin
				out_mixed_sample <= 16'sh8000;
				out_clipped <= 1'b1;
			end else begin
				out_mixed_sample <= total[15:0];
				out_clipped <= 1'b0;
			end
			out_voices_playing <= 4'(count);
			out_music_swapped <= swapped_q;
		end
	end

endmodule

@@ hw/rtl/vmx_checker.sv @@
// Port-level checks of the voice mixer, bound to the top level.
module vmx_checker #(
	parameter int VOICES = vmx_pkg::VOICES_DEF
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [vmx_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import vmx_pkg::*;

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item taken while previous item in work");

	a_clip_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[16] |->
		(m_tdata[15:0] == 16'h7fff || m_tdata[15:0] == 16'h8000))
		else $error("clipped result not at a rail");

	a_voice_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[20:17] <= 4'(VOICES)))
		else $error("voice count above voice total");

endmodule

bind voice_mixer_with_music_crossfade vmx_checker #(.VOICES(VOICES)) u_vmx_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
